// ----- hw/rtl/tld_pkg.sv -----
// Shared types, constants and helpers for the tty line discipline.
// No dependencies; compile first.
`default_nettype none

package tld_pkg;

   // Default sizes
   localparam int BUF_DEPTH_DEF = 256;
   localparam int MAX_READ_DEF  = 64;

   // Command queue between front and back (power of two)
   localparam int QUEUE_DEPTH = 2;

   // Register port
   localparam int CSR_AW = 5;
   localparam int CSR_DW = 32;

   // Field widths
   localparam int CNT_W  = 7;
   localparam int FILL_W = 9;
   localparam int MODE_W = 7;

   // Characters
   localparam logic [7:0] CH_NL = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   // Mode flag bit positions
   localparam int MODE_ISIG   = 0;
   localparam int MODE_CANON  = 1;
   localparam int MODE_ECHO   = 2;
   localparam int MODE_IEXTEN = 3;
   localparam int MODE_IGNCR  = 4;
   localparam int MODE_ICRNL  = 5;
   localparam int MODE_INLCR  = 6;

   // Register reset values
   localparam logic [MODE_W-1:0] MODE_RST = 7'd39;
   localparam logic [7:0] INTR_RST   = 8'd3;
   localparam logic [7:0] QUIT_RST   = 8'd28;
   localparam logic [7:0] SUSP_RST   = 8'd26;
   localparam logic [7:0] ERASE_RST  = 8'd127;
   localparam logic [7:0] WERASE_RST = 8'd23;
   localparam logic [7:0] EOL_RST    = 8'd255;

   typedef enum logic [2:0] {
      REG_MODE   = 3'd0,
      REG_INTR   = 3'd1,
      REG_QUIT   = 3'd2,
      REG_SUSP   = 3'd3,
      REG_ERASE  = 3'd4,
      REG_WERASE = 3'd5,
      REG_EOL    = 3'd6
   } reg_index_type;

   typedef enum logic [1:0] {
      OP_REPORT = 2'd0,
      OP_ERASE  = 2'd1,
      OP_STORE  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      SIG_NONE   = 3'd0,
      SIG_INTR   = 3'd1,
      SIG_QUIT   = 3'd2,
      SIG_SUSP   = 3'd3,
      SIG_WERASE = 3'd4
   } sig_type;

   typedef enum logic [1:0] {
      RK_HANDLED = 2'd0,
      RK_BYTE    = 2'd1,
      RK_EMPTY   = 2'd2
   } rkind_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [7:0]        intr_char;
      logic [7:0]        quit_char;
      logic [7:0]        susp_char;
      logic [7:0]        erase_char;
      logic [7:0]        werase_char;
      logic [7:0]        eol_char;
   } cfg_type;

   typedef struct packed {
      op_type           op;
      sig_type          sig;
      logic [7:0]       ch;
      logic             echo;
      logic [CNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      rkind_type         result_kind;
      logic [7:0]        data_byte;
      logic              echo_valid;
      logic [7:0]        echo_byte;
      sig_type           signal_code;
      logic              dropped;
      logic [FILL_W-1:0] fill_level;
      logic              last;
   } rsp_type;

   function automatic logic is_line_end(input logic [7:0] c, input logic [7:0] eol);
      is_line_end = (c == CH_NL) || (c == eol);
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/tld_if.sv -----
// Valid/ready channel interfaces for the tty line discipline.
// Request beats carry one character or one read request; response beats one result.
`default_nettype none

interface tld_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] in_byte;
   logic [6:0] read_max;

   modport source (output valid, output kind, output in_byte, output read_max, input ready);
   modport sink   (input valid, input kind, input in_byte, input read_max, output ready);
endinterface

interface tld_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] result_kind;
   logic [7:0] data_byte;
   logic       echo_valid;
   logic [7:0] echo_byte;
   logic [2:0] signal_code;
   logic       dropped;
   logic [8:0] fill_level;
   logic       last;

   modport source (output valid, output result_kind, output data_byte, output echo_valid,
                   output echo_byte, output signal_code, output dropped, output fill_level,
                   output last, input ready);
   modport sink   (input valid, input result_kind, input data_byte, input echo_valid,
                   input echo_byte, input signal_code, input dropped, input fill_level,
                   input last, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/tld_front.sv -----
// Front end: accept request beats and classify them into commands.
// Depends on tld_pkg and tld_req_if.
`default_nettype none

module tld_front
   import tld_pkg::*;
#(
   parameter int MAX_READ = MAX_READ_DEF
) (
   tld_req_if.sink   req,
   input  cfg_type   cfg,
   input  logic      push_ready,
   output logic      push_valid,
   output cmd_type   push_cmd
);

   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_READ);

   logic [7:0] mapped;

   assign push_valid = req.valid;
   assign req.ready  = push_ready;

   always_comb begin
      push_cmd       = '0;
      push_cmd.op    = OP_STORE;
      push_cmd.sig   = SIG_NONE;
      mapped         = req.in_byte;
      if (req.in_byte == CH_CR && cfg.mode[MODE_ICRNL]) begin
         mapped = CH_NL;
      end else if (req.in_byte == CH_NL && cfg.mode[MODE_INLCR]) begin
         mapped = CH_CR;
      end

      if (req.kind) begin
         push_cmd.op    = OP_READ;
         push_cmd.count = (req.read_max > MAX_CNT) ? MAX_CNT : req.read_max;
      end else if (cfg.mode[MODE_ISIG] && req.in_byte == cfg.intr_char) begin
         push_cmd.op  = OP_REPORT;
         push_cmd.sig = SIG_INTR;
      end else if (cfg.mode[MODE_ISIG] && req.in_byte == cfg.quit_char) begin
         push_cmd.op  = OP_REPORT;
         push_cmd.sig = SIG_QUIT;
      end else if (cfg.mode[MODE_ISIG] && req.in_byte == cfg.susp_char) begin
         push_cmd.op  = OP_REPORT;
         push_cmd.sig = SIG_SUSP;
      end else if (req.in_byte == CH_CR && cfg.mode[MODE_IGNCR]) begin
         push_cmd.op = OP_REPORT;
      end else if (cfg.mode[MODE_CANON] && mapped == cfg.erase_char) begin
         push_cmd.op = OP_ERASE;
      end else if (cfg.mode[MODE_CANON] && cfg.mode[MODE_IEXTEN]
                   && mapped == cfg.werase_char) begin
         push_cmd.op  = OP_REPORT;
         push_cmd.sig = SIG_WERASE;
      end else begin
         push_cmd.ch   = mapped;
         push_cmd.echo = cfg.mode[MODE_ECHO];
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tld_queue.sv -----
// Short command queue between the front and back ends.
// Depends on tld_pkg.
`default_nettype none

module tld_queue
   import tld_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   input  cmd_type push_cmd,
   output logic    push_ready,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int QAW = $clog2(QUEUE_DEPTH);
   localparam int QCW = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [QAW-1:0]   wr_idx_ff, wr_idx_in;
   logic [QAW-1:0]   rd_idx_ff, rd_idx_in;
   logic [QCW-1:0]   count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != QCW'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_idx_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   always_comb begin
      wr_idx_in = do_push ? wr_idx_ff + 1'b1 : wr_idx_ff;
      rd_idx_in = do_pop ? rd_idx_ff + 1'b1 : rd_idx_ff;
      count_in  = count_ff + QCW'(do_push) - QCW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_idx_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/tld_back.sv -----
// Back end: ring buffer, erase and read sequencing, response register.
// Depends on tld_pkg and tld_rsp_if.
`default_nettype none

module tld_back
   import tld_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] eol_char,
   input  logic       pop_valid,
   input  cmd_type    pop_cmd,
   output logic       pop,
   tld_rsp_if.source  rsp
);

   localparam int AW = $clog2(BUF_DEPTH);
   localparam int FW = $clog2(BUF_DEPTH + 1);
   localparam int CW = (FW > CNT_W) ? FW : CNT_W;
   localparam logic [AW-1:0] LAST_ADDR = AW'(BUF_DEPTH - 1);
   localparam logic [FW-1:0] FULL      = FW'(BUF_DEPTH);

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_ERASE = 3'b010,
      ST_READ  = 3'b100
   } state_type;

   logic [7:0]       ring_store [BUF_DEPTH];

   state_type        state_ff, state_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [AW-1:0]    rp_ff, rp_in;
   logic [FW-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic [7:0]       rd_data_ff;
   rsp_type          out_ff;
   logic             out_valid_ff, out_valid_in;

   logic             slot_ok;
   logic             load;
   logic             wr_en;
   logic             rd_en;
   logic [AW-1:0]    rd_addr;
   logic [AW-1:0]    wp_prev, wp_next, rp_next;
   logic [CW-1:0]    cnt_ext, fill_ext;
   logic [CNT_W-1:0] n_eff;
   logic             read_end;
   rsp_type          res;

   assign slot_ok = !out_valid_ff || rsp.ready;
   assign wp_prev = (wp_ff == '0) ? LAST_ADDR : wp_ff - 1'b1;
   assign wp_next = (wp_ff == LAST_ADDR) ? '0 : wp_ff + 1'b1;
   assign rp_next = (rp_ff == LAST_ADDR) ? '0 : rp_ff + 1'b1;
   assign cnt_ext  = CW'(pop_cmd.count);
   assign fill_ext = CW'(fill_ff);
   assign n_eff    = (cnt_ext < fill_ext) ? pop_cmd.count : CNT_W'(fill_ff);
   assign read_end = is_line_end(rd_data_ff, eol_char) || (remain_ff == CNT_W'(1));

   always_comb begin
      state_in  = state_ff;
      wp_in     = wp_ff;
      rp_in     = rp_ff;
      fill_in   = fill_ff;
      remain_in = remain_ff;
      pop       = 1'b0;
      load      = 1'b0;
      wr_en     = 1'b0;
      rd_en     = 1'b0;
      rd_addr   = rp_ff;
      res       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid && slot_ok) begin
               pop = 1'b1;
               unique case (pop_cmd.op)
                  OP_REPORT: begin
                     load            = 1'b1;
                     res.signal_code = pop_cmd.sig;
                     res.last        = 1'b1;
                  end
                  OP_STORE: begin
                     load           = 1'b1;
                     res.echo_valid = pop_cmd.echo;
                     res.echo_byte  = pop_cmd.echo ? pop_cmd.ch : 8'd0;
                     res.last       = 1'b1;
                     if (fill_ff < FULL) begin
                        wr_en   = 1'b1;
                        wp_in   = wp_next;
                        fill_in = fill_ff + 1'b1;
                     end else begin
                        res.dropped = 1'b1;
                     end
                  end
                  OP_ERASE: begin
                     rd_en    = 1'b1;
                     rd_addr  = wp_prev;
                     state_in = ST_ERASE;
                  end
                  OP_READ: begin
                     if (n_eff == '0) begin
                        load            = 1'b1;
                        res.result_kind = RK_EMPTY;
                        res.last        = 1'b1;
                     end else begin
                        rd_en     = 1'b1;
                        rd_addr   = rp_ff;
                        remain_in = n_eff;
                        state_in  = ST_READ;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ERASE: begin
            if (slot_ok) begin
               load     = 1'b1;
               res.last = 1'b1;
               state_in = ST_IDLE;
               // Never erase past the start of the line
               if (fill_ff != '0 && !is_line_end(rd_data_ff, eol_char)) begin
                  wp_in   = wp_prev;
                  fill_in = fill_ff - 1'b1;
               end
            end
         end
         ST_READ: begin
            if (slot_ok) begin
               load            = 1'b1;
               res.result_kind = RK_BYTE;
               res.data_byte   = rd_data_ff;
               res.last        = read_end;
               rp_in           = rp_next;
               fill_in         = fill_ff - 1'b1;
               remain_in       = remain_ff - 1'b1;
               if (read_end) begin
                  state_in = ST_IDLE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = rp_next;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      res.fill_level = FILL_W'(fill_in);
      out_valid_in   = load ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         fill_ff      <= '0;
         remain_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         fill_ff      <= fill_in;
         remain_ff    <= remain_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff <= res;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ring_store[wp_ff] <= pop_cmd.ch;
      end
      if (rd_en) begin
         rd_data_ff <= ring_store[rd_addr];
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.result_kind = out_ff.result_kind;
   assign rsp.data_byte   = out_ff.data_byte;
   assign rsp.echo_valid  = out_ff.echo_valid;
   assign rsp.echo_byte   = out_ff.echo_byte;
   assign rsp.signal_code = out_ff.signal_code;
   assign rsp.dropped     = out_ff.dropped;
   assign rsp.fill_level  = out_ff.fill_level;
   assign rsp.last        = out_ff.last;

`ifndef SYNTHESIS
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL)
      else $error("ring fill count above depth");

   a_read_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ |-> remain_ff != '0)
      else $error("read burst with no bytes left");

   a_erase_seq: assert property (@(posedge clock) disable iff (reset)
      pop && pop_cmd.op == OP_ERASE |=> state_ff == ST_ERASE)
      else $error("erase did not enter lookup state");

   a_read_drain: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_READ && slot_ok |=> fill_ff == $past(fill_ff) - 1'b1)
      else $error("read byte did not drain the ring");

   a_port_excl: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !rd_en)
      else $error("ring written and read in one cycle");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/tty_line_discipline.sv -----
// Top level of the tty line discipline: register file, front, queue, back.
// Depends on tld_pkg, tld_if, tld_front, tld_queue and tld_back.
//
//   channel   direction  beat                               handshake
//   req_chan  in         one character or one read request  valid/ready
//   rsp_chan  out        one result (byte, echo or report)   valid/ready
//   APB       in         register write/read                psel/penable, pready
//
// A request beat enters a two-entry command queue, so ready stays high while
// fewer than two commands wait for the back end. The back end completes a
// character command straight from idle, an erase after one ring lookup, and a
// read of n bytes by first fetching the first byte, then returning one byte
// per cycle while rsp_chan is not stalled, through the single read port of
// the ring memory.
// Reset is synchronous and clears pointers, fill count and control state;
// the ring memory is not cleared and needs no sweep.
// A stalled rsp_chan holds the output register, the back end waits, the
// queue fills and req_chan.ready drops.
`default_nettype none

module tty_line_discipline
   import tld_pkg::*;
#(
   parameter int BUF_DEPTH = BUF_DEPTH_DEF,
   parameter int MAX_READ  = MAX_READ_DEF
) (
   input  logic              clock,
   input  logic              reset,
   tld_req_if.sink           req_chan,
   tld_rsp_if.source         rsp_chan,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_idx;
   logic          csr_wr;

   logic          push_valid, push_ready;
   cmd_type       push_cmd;
   logic          pop, pop_valid;
   cmd_type       pop_cmd;

   // Register file: word addressed, low address bits ignored
   assign pready  = 1'b1;
   assign reg_idx = reg_index_type'(paddr[4:2]);
   assign csr_wr  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (reg_idx)
            REG_MODE:   cfg_in.mode        = pwdata[MODE_W-1:0];
            REG_INTR:   cfg_in.intr_char   = pwdata[7:0];
            REG_QUIT:   cfg_in.quit_char   = pwdata[7:0];
            REG_SUSP:   cfg_in.susp_char   = pwdata[7:0];
            REG_ERASE:  cfg_in.erase_char  = pwdata[7:0];
            REG_WERASE: cfg_in.werase_char = pwdata[7:0];
            REG_EOL:    cfg_in.eol_char    = pwdata[7:0];
            default: ;  // unmapped address: drop the write
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_MODE:   prdata = CSR_DW'(cfg_ff.mode);
         REG_INTR:   prdata = CSR_DW'(cfg_ff.intr_char);
         REG_QUIT:   prdata = CSR_DW'(cfg_ff.quit_char);
         REG_SUSP:   prdata = CSR_DW'(cfg_ff.susp_char);
         REG_ERASE:  prdata = CSR_DW'(cfg_ff.erase_char);
         REG_WERASE: prdata = CSR_DW'(cfg_ff.werase_char);
         REG_EOL:    prdata = CSR_DW'(cfg_ff.eol_char);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode        <= MODE_RST;
         cfg_ff.intr_char   <= INTR_RST;
         cfg_ff.quit_char   <= QUIT_RST;
         cfg_ff.susp_char   <= SUSP_RST;
         cfg_ff.erase_char  <= ERASE_RST;
         cfg_ff.werase_char <= WERASE_RST;
         cfg_ff.eol_char    <= EOL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Classify the incoming beat into a command
   tld_front #(
      .MAX_READ   (MAX_READ)
   ) u_front (
      .req        (req_chan),
      .cfg        (cfg_ff),
      .push_ready (push_ready),
      .push_valid (push_valid),
      .push_cmd   (push_cmd)
   );

   // Decouple acceptance from execution
   tld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_cmd    (pop_cmd)
   );

   // Execute against the ring buffer and drive results
   tld_back #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .eol_char  (cfg_ff.eol_char),
      .pop_valid (pop_valid),
      .pop_cmd   (pop_cmd),
      .pop       (pop),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire
